@@ src/rrts_pkg.sv @@
package rrts_pkg;

  // Table size and derived widths
  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  // common width for comparing an entry index against a 4-bit task index
  localparam int CMP_W     = (IDX_W > 4) ? IDX_W : 4;

  // Operation codes
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_CREATE   = 3'd1;
  localparam logic [2:0] OP_DELAY    = 3'd2;
  localparam logic [2:0] OP_SUSPEND  = 3'd3;
  localparam logic [2:0] OP_ACTIVATE = 3'd4;

  // Task status; the running task is the ready task at the current index,
  // so running and ready share one code.
  typedef enum logic [1:0] {
    ST_READY     = 2'd0,
    ST_WAITING   = 2'd2,
    ST_SUSPENDED = 2'd3
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] wait_left;
  } entry_t;

  // Per-cycle control for the entry update at the head of the chain
  typedef struct packed {
    logic [2:0]  func;
    logic        in_range;
    logic        is_cur;
    logic        is_tgt;
    logic        is_new;
    logic        susp;
    logic [31:0] delay;
  } upd_ctl_t;

endpackage

@@ src/rrts_cell.sv @@
module rrts_cell (
  input  logic            clk,
  input  logic            shift,
  input  rrts_pkg::entry_t d,
  output rrts_pkg::entry_t q
);
  import rrts_pkg::*;

  // One task entry; moves one place toward the head on each shift
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

@@ src/rrts_entry_upd.sv @@
module rrts_entry_upd (
  input  rrts_pkg::upd_ctl_t ctl,
  input  rrts_pkg::entry_t   e_in,
  output rrts_pkg::entry_t   e_out,
  output logic               runnable
);
  import rrts_pkg::*;

  logic [31:0] dec;

  assign dec = e_in.wait_left - 32'd1;

  // Apply the current request to the entry at the head
  always_comb begin
    e_out = e_in;
    if (ctl.in_range) begin
      unique case (ctl.func)
        OP_TICK: begin
          if (e_in.status == ST_WAITING) begin
            e_out.wait_left = dec;
            if (dec == 32'd0) e_out.status = ST_READY;
          end
        end
        OP_DELAY: begin
          if (ctl.is_cur) begin
            e_out.status    = ST_WAITING;
            e_out.wait_left = (ctl.delay == 32'd0) ? 32'd1 : ctl.delay;
          end
        end
        OP_SUSPEND: begin
          if (ctl.is_cur) e_out.status = ST_SUSPENDED;
        end
        OP_ACTIVATE: begin
          if (ctl.is_tgt) e_out.status = ST_READY;
        end
        default: begin
        end
      endcase
    end
    // new entry slot on create
    if (ctl.is_new) begin
      e_out.status    = ctl.susp ? ST_SUSPENDED : ST_READY;
      e_out.wait_left = 32'd0;
    end
  end

  assign runnable = ctl.in_range && (e_out.status == ST_READY);

endmodule

@@ src/round_robin_task_scheduler_unit.sv @@
// Channel  | Handshake           | Payload
// ---------+---------------------+---------------------------------------------
// in       | in_valid / in_ready | func, task_index, delay_ticks,
//          |                     | start_suspended
// out      | out_valid/out_ready | running_task, switched, new_task,
//          |                     | create_ok, tick_count
//
// Each request goes through accept, one pass of the task entries around the
// cell ring, and a result state that holds until the result is taken.
// The ring rotates one entry per cycle past a single update unit, which sets
// the per-request length. One request is in work at a time; in_ready is low
// until the result is taken. Reset clears task count, current index and tick
// counter; the task entries are not cleared and are only used once created.
module round_robin_task_scheduler_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [3:0]  task_index,
  input  logic [31:0] delay_ticks,
  input  logic        start_suspended,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  running_task,
  output logic        switched,
  output logic [3:0]  new_task,
  output logic        create_ok,
  output logic [31:0] tick_count
);
  import rrts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);

  state_t            state, state_next;
  logic [IDX_W-1:0]  head_idx;
  logic [CNT_W-1:0]  total;
  logic [IDX_W-1:0]  cur;
  logic [31:0]       global_ticks;

  logic [2:0]        func_q;
  logic [3:0]        tidx_q;
  logic [31:0]       delay_q;
  logic              susp_q;
  logic              have_cur;

  logic              found_after, found_before;
  logic [IDX_W-1:0]  pick_after, pick_before;
  logic              found_after_next, found_before_next;
  logic [IDX_W-1:0]  pick_after_next, pick_before_next;

  entry_t            chain [MAX_TASKS];
  entry_t            head_upd;
  upd_ctl_t          ctl;
  logic              head_run;
  logic              shift;
  logic              last;
  logic              dispatch;
  logic              create_fits;
  logic [IDX_W-1:0]  pick;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_DONE);
  assign shift     = (state == S_WALK);
  assign last      = shift && (head_idx == LAST_IDX);

  // Ring of task cells; the head feeds the update unit, which refills the tail
  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_ring
    if (i == MAX_TASKS - 1) begin : g_tail
      rrts_cell u_cell (.clk(clk), .shift(shift), .d(head_upd), .q(chain[i]));
    end else begin : g_mid
      rrts_cell u_cell (.clk(clk), .shift(shift), .d(chain[i+1]), .q(chain[i]));
    end
  end

  // Control for the entry now at the head
  assign create_fits = (total < CNT_W'(MAX_TASKS));

  always_comb begin
    ctl          = '0;
    ctl.func     = func_q;
    ctl.in_range = (CNT_W'(head_idx) < total);
    ctl.is_cur   = have_cur && (head_idx == cur);
    ctl.is_tgt   = (CMP_W'(head_idx) == CMP_W'(tidx_q));
    ctl.is_new   = (func_q == OP_CREATE) && create_fits && (CNT_W'(head_idx) == total);
    ctl.susp     = susp_q;
    ctl.delay    = delay_q;
  end

  rrts_entry_upd u_upd (
    .ctl     (ctl),
    .e_in    (chain[0]),
    .e_out   (head_upd),
    .runnable(head_run)
  );

  // Round robin search: first runnable above current, else first at or below
  always_comb begin
    found_after_next  = found_after;
    found_before_next = found_before;
    pick_after_next   = pick_after;
    pick_before_next  = pick_before;
    if (head_run) begin
      if (head_idx > cur) begin
        if (!found_after) begin
          found_after_next = 1'b1;
          pick_after_next  = head_idx;
        end
      end else if (!found_before) begin
        found_before_next = 1'b1;
        pick_before_next  = head_idx;
      end
    end
  end

  always_comb begin
    priority if (found_after_next) pick = pick_after_next;
    else if (found_before_next)    pick = pick_before_next;
    else                           pick = cur;
  end

  assign dispatch = have_cur && ((func_q == OP_TICK) || (func_q == OP_DELAY) ||
                                 (func_q == OP_SUSPEND) || (func_q == OP_ACTIVATE));

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_WALK;
      S_WALK:  if (last) state_next = S_DONE;
      S_DONE:  if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head_idx     <= '0;
      total        <= '0;
      cur          <= '0;
      global_ticks <= '0;
    end else begin
      state <= state_next;
      if (shift) begin
        head_idx <= last ? '0 : head_idx + IDX_W'(1);
      end
      if (last) begin
        if (func_q == OP_TICK) global_ticks <= global_ticks + 32'd1;
        if ((func_q == OP_CREATE) && create_fits) total <= total + CNT_W'(1);
        if (dispatch) cur <= pick;
      end
    end
  end

  // Request capture, search state and result registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_q       <= func;
      tidx_q       <= task_index;
      delay_q      <= delay_ticks;
      susp_q       <= start_suspended;
      have_cur     <= (total != '0) && (CNT_W'(cur) < total);
      found_after  <= 1'b0;
      found_before <= 1'b0;
      pick_after   <= '0;
      pick_before  <= '0;
    end else if (shift) begin
      found_after  <= found_after_next;
      found_before <= found_before_next;
      pick_after   <= pick_after_next;
      pick_before  <= pick_before_next;
    end
    if (last) begin
      running_task <= dispatch ? 4'(pick) : 4'(cur);
      switched     <= dispatch && (pick != cur);
      create_ok    <= (func_q == OP_CREATE) && create_fits;
      new_task     <= ((func_q == OP_CREATE) && create_fits) ? 4'(total) : 4'd0;
      tick_count   <= (func_q == OP_TICK) ? global_ticks + 32'd1 : global_ticks;
    end
  end

`ifndef SYNTH
  // ring walk runs its full length without a break
  a_walk_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && head_idx != LAST_IDX) |=> (state == S_WALK))
    else $error("task ring walk ended early");

  // ring is back in index order whenever it is at rest
  a_ring_home: assert property (@(posedge clk) disable iff (rst)
    (state != S_WALK) |-> (head_idx == '0))
    else $error("task ring left out of alignment");

  // current task always lies inside the created range
  a_cur_range: assert property (@(posedge clk) disable iff (rst)
    (total != '0) |-> (CNT_W'(cur) < total))
    else $error("current task index beyond task count");

  a_total_max: assert property (@(posedge clk) disable iff (rst)
    total <= CNT_W'(MAX_TASKS))
    else $error("task count above table size");

  // create never reports a task switch
  a_create_sw: assert property (@(posedge clk) disable iff (rst)
    (out_valid && create_ok) |-> !switched)
    else $error("switch reported on create");
`endif

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import rrts_pkg::*;

  // func codes the block leaves alone
  localparam logic [2:0] OP_UNUSED_FIRST = OP_ACTIVATE + 3'd1;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
  localparam int REQ_CYCLES = MAX_TASKS + 2;
  localparam int RANDOM_PER_PHASE = 112;

  // predictor keeps running apart from ready
  typedef enum logic [1:0] {
    T_READY, T_RUNNING, T_WAITING, T_SUSPENDED
  } pred_status_t;

  typedef struct packed {
    logic [3:0]  running_task;
    logic        switched;
    logic [3:0]  new_task;
    logic        create_ok;
    logic [31:0] tick_count;
  } sched_result_t;

  // Scheduler predictor and the queue of results it expects
  class sched_scoreboard;
    pred_status_t  state_tbl[MAX_TASKS];
    logic [31:0]   wait_tbl[MAX_TASKS];
    int unsigned   n_tasks;
    int unsigned   cur;
    logic [31:0]   ticks;
    sched_result_t expected_q[$];
    int unsigned   mismatches;

    function new();
      n_tasks    = 0;
      cur        = 0;
      ticks      = '0;
      mismatches = 0;
    endfunction

    function bit runnable(int unsigned idx);
      return state_tbl[idx] == T_READY || state_tbl[idx] == T_RUNNING;
    endfunction

    // round robin pick, searching from the entry after the current one
    function bit pick_next();
      int unsigned k;
      int unsigned idx;
      int unsigned pick;
      bit found;
      if (n_tasks == 0 || cur >= n_tasks) return 1'b0;
      pick  = cur;
      found = 1'b0;
      for (k = 1; k <= n_tasks; k++) begin
        idx = (cur + k) % n_tasks;
        if (!found && runnable(idx)) begin
          pick  = idx;
          found = 1'b1;
        end
      end
      if (pick != cur) begin
        if (state_tbl[cur] == T_RUNNING) state_tbl[cur] = T_READY;
        cur = pick;
        state_tbl[pick] = T_RUNNING;
        return 1'b1;
      end
      if (runnable(pick)) state_tbl[pick] = T_RUNNING;
      return 1'b0;
    endfunction

    // accepted request: advance the task table and queue the result
    function void note_request(logic [2:0] f, logic [3:0] idx, logic [31:0] dly,
                               logic susp);
      sched_result_t r;
      bit have_cur;
      int unsigned i;
      r = '0;
      have_cur = (n_tasks > 0) && (cur < n_tasks);
      case (f)
        OP_TICK: begin
          ticks = ticks + 32'd1;
          for (i = 0; i < n_tasks; i++) begin
            if (state_tbl[i] == T_WAITING) begin
              wait_tbl[i] = wait_tbl[i] - 32'd1;
              if (wait_tbl[i] == 32'd0) state_tbl[i] = T_READY;
            end
          end
          r.switched = pick_next();
        end
        OP_CREATE: begin
          if (n_tasks < MAX_TASKS) begin
            state_tbl[n_tasks] = susp ? T_SUSPENDED : T_READY;
            wait_tbl[n_tasks]  = '0;
            r.new_task  = n_tasks[3:0];
            r.create_ok = 1'b1;
            n_tasks++;
          end
        end
        OP_DELAY: begin
          if (have_cur) begin
            state_tbl[cur] = T_WAITING;
            // zero delay waits one tick
            wait_tbl[cur]  = (dly == 32'd0) ? 32'd1 : dly;
          end
          r.switched = pick_next();
        end
        OP_SUSPEND: begin
          if (have_cur) state_tbl[cur] = T_SUSPENDED;
          r.switched = pick_next();
        end
        OP_ACTIVATE: begin
          if (idx < n_tasks && state_tbl[idx] != T_RUNNING) state_tbl[idx] = T_READY;
          r.switched = pick_next();
        end
        default: ;
      endcase
      r.running_task = cur[3:0];
      r.tick_count   = ticks;
      expected_q.push_back(r);
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(sched_result_t got);
      sched_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result run=%0d sw=%0d new=%0d ok=%0d ticks=%0d",
                   got.running_task, got.switched, got.new_task, got.create_ok,
                   got.tick_count);
        return;
      end
      want = expected_q.pop_front();
      if (got.running_task !== want.running_task || got.switched !== want.switched ||
          got.new_task !== want.new_task || got.create_ok !== want.create_ok ||
          got.tick_count !== want.tick_count) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result mismatch exp run=%0d sw=%0d new=%0d ok=%0d ticks=%0d",
                   want.running_task, want.switched, want.new_task, want.create_ok,
                   want.tick_count);
          $display("                       got run=%0d sw=%0d new=%0d ok=%0d ticks=%0d",
                   got.running_task, got.switched, got.new_task, got.create_ok,
                   got.tick_count);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst             = 1'b1;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic [2:0]  func            = OP_TICK;
  logic [3:0]  task_index      = '0;
  logic [31:0] delay_ticks     = '0;
  logic        start_suspended = 1'b0;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  logic [3:0]  running_task;
  logic        switched;
  logic [3:0]  new_task;
  logic        create_ok;
  logic [31:0] tick_count;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  sched_scoreboard sb = new();

  round_robin_task_scheduler_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .task_index(task_index), .delay_ticks(delay_ticks),
    .start_suspended(start_suspended),
    .out_valid(out_valid), .out_ready(out_ready),
    .running_task(running_task), .switched(switched), .new_task(new_task),
    .create_ok(create_ok), .tick_count(tick_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side: check on handshake, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result({running_task, switched, new_task, create_ok, tick_count});
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // present one request and hold it until accepted; called at a clock edge
  task automatic send_request(logic [2:0] f, logic [3:0] idx, logic [31:0] dly,
                              logic susp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    func            <= f;
    task_index      <= idx;
    delay_ticks     <= dly;
    start_suspended <= susp;
    do @(posedge clk); while (!in_ready);
    sb.note_request(f, idx, dly, susp);
  endtask

  // random request, weighted toward ticks and activates to keep tasks moving
  task automatic random_request();
    int unsigned roll;
    logic [2:0]  f;
    logic [31:0] dly;
    roll = $urandom_range(99);
    if (roll < 35)      f = OP_TICK;
    else if (roll < 40) f = OP_CREATE;
    else if (roll < 58) f = OP_DELAY;
    else if (roll < 68) f = OP_SUSPEND;
    else if (roll < 95) f = OP_ACTIVATE;
    else                f = 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
    dly = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(6);
    send_request(f, 4'($urandom_range(15)), dly, 1'($urandom_range(1)));
  endtask

  // drop valid and hold off until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    int unsigned phase;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table: nothing to run, ticks still count
    send_request(OP_TICK, 4'd0, 32'd0, 1'b0);
    send_request(OP_DELAY, 4'd0, 32'd0, 1'b0);
    send_request(OP_SUSPEND, 4'd0, 32'd0, 1'b0);
    send_request(OP_ACTIVATE, 4'd15, 32'hFFFF_FFFF, 1'b1);
    send_request(OP_UNUSED_FIRST, 4'd0, 32'd0, 1'b0);
    send_request(OP_UNUSED_LAST, 4'd15, 32'hFFFF_FFFF, 1'b1);
    // a few tasks, one starting suspended
    send_request(OP_CREATE, 4'd0, 32'd0, 1'b0);
    send_request(OP_CREATE, 4'd0, 32'd0, 1'b1);
    send_request(OP_CREATE, 4'd0, 32'd0, 1'b0);
    send_request(OP_TICK, 4'd0, 32'd0, 1'b0);
    send_request(OP_ACTIVATE, 4'd1, 32'd0, 1'b0);
    // out of range, then the running task itself
    send_request(OP_ACTIVATE, 4'd15, 32'd0, 1'b0);
    send_request(OP_ACTIVATE, sb.cur[3:0], 32'd0, 1'b0);
    send_request(OP_DELAY, 4'd0, 32'd0, 1'b0);
    send_request(OP_TICK, 4'd0, 32'd0, 1'b0);
    send_request(OP_DELAY, 4'd0, 32'hFFFF_FFFF, 1'b0);
    send_request(OP_SUSPEND, 4'd0, 32'd0, 1'b0);
    // leaves no task runnable
    send_request(OP_SUSPEND, 4'd0, 32'd0, 1'b0);
    send_request(OP_TICK, 4'd0, 32'd0, 1'b0);
    send_request(OP_UNUSED_FIRST + 3'd1, 4'd0, 32'd0, 1'b0);
    send_request(OP_ACTIVATE, 4'd0, 32'd0, 1'b0);
    send_request(OP_ACTIVATE, 4'd2, 32'd0, 1'b0);

    // random phases: no idling, sender idle, receiver stall, both light
    for (phase = 0; phase < 4; phase++) begin
      drain_results();
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      repeat (RANDOM_PER_PHASE) random_request();
      // make sure the full table and a refused create are seen
      if (phase == 0)
        while (sb.n_tasks < MAX_TASKS) send_request(OP_CREATE, 4'd0, 32'd0, 1'b0);
      if (phase == 0) send_request(OP_CREATE, 4'd15, 32'hFFFF_FFFF, 1'b1);
    end

    drain_results();
    repeat (2 * REQ_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("PASS round_robin_task_scheduler_unit");
    else
      $display("FAIL round_robin_task_scheduler_unit");
    $finish;
  end

  // hang guard
  initial begin
    #5_000_000;
    $display("FAIL round_robin_task_scheduler_unit");
    $finish;
  end

endmodule
